// ===== rtl/prfd_pkg.sv =====
// ----------------------------------------------------------------------------
// prfd_pkg - shared definitions for the probe reply filter
// Frame classification codes, verdict codes, register indexes, hash constants
// and the structs that run between the sequencer, hash engine and filter store.
// ----------------------------------------------------------------------------
package prfd_pkg;

  // Header values
  localparam logic [15:0] ETHERTYPE_IPV6      = 16'h86DD;
  localparam logic [7:0]  NEXT_HDR_ICMPV6     = 8'd58;
  localparam logic [7:0]  ICMPV6_ECHO_REPLY   = 8'd129;
  localparam logic [7:0]  ICMPV6_NEIGH_ADVERT = 8'd136;

  // Filter size default (bits of bit index)
  localparam int FILTER_INDEX_BITS_DEF = 20;

  // Configuration registers
  localparam int CFG_DATA_W = 32;
  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_CHECKSUM_SEED = 2'd0;
  localparam cfg_idx_t CFG_FIRST_SEED    = 2'd1;
  localparam cfg_idx_t CFG_SECOND_SEED   = 2'd2;

  localparam logic [31:0] CHECKSUM_SEED_RST = 32'h1111_2222;
  localparam logic [31:0] FIRST_SEED_RST    = 32'h1234_5678;
  localparam logic [31:0] SECOND_SEED_RST   = 32'h8765_4321;

  // MurmurHash3 x86_32 constants
  localparam logic [31:0] MM_C1   = 32'hcc9e_2d51;
  localparam logic [31:0] MM_C2   = 32'h1b87_3593;
  localparam logic [31:0] MM_N    = 32'he654_6b64;
  localparam logic [31:0] MM_F1   = 32'h85eb_ca6b;
  localparam logic [31:0] MM_F2   = 32'hc2b2_ae35;
  localparam logic [31:0] LEN_CHK = 32'd12;
  localparam logic [31:0] LEN_ALL = 32'd16;

  typedef enum logic [2:0] {
    VERDICT_ACCEPT     = 3'd0,
    VERDICT_NOT_IPV6   = 3'd1,
    VERDICT_NOT_ICMPV6 = 3'd2,
    VERDICT_WRONG_TYPE = 3'd3,
    VERDICT_CSUM_BAD   = 3'd4,
    VERDICT_DUPLICATE  = 3'd5
  } verdict_t;

  typedef struct packed {
    logic [31:0] chk_seed;
    logic [31:0] first_seed;
    logic [31:0] second_seed;
  } seeds_t;

  typedef struct packed {
    logic        done;
    logic [31:0] chk_hash;
    logic [31:0] first_hash;
    logic [31:0] second_hash;
  } hash_rsp_t;

  typedef struct packed {
    logic rd_en;
    logic set_en;
  } bloom_cmd_t;

  typedef struct packed {
    logic ready;
    logic rd_bit;
  } bloom_sts_t;

endpackage

// ===== rtl/prfd_if.sv =====
// ----------------------------------------------------------------------------
// prfd_if - request and result channels of the probe reply filter
// Valid/ready channels; a request moves on an edge with valid and ready high.
// ----------------------------------------------------------------------------
interface prfd_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] ether_type;
  logic [7:0]  next_header;
  logic [7:0]  icmp_type;
  logic [63:0] src_addr_high;
  logic [63:0] src_addr_low;

  modport source (
    output valid, ether_type, next_header, icmp_type, src_addr_high, src_addr_low,
    input  ready
  );
  modport sink (
    input  valid, ether_type, next_header, icmp_type, src_addr_high, src_addr_low,
    output ready
  );
endinterface

interface prfd_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  verdict;
  logic [63:0] responder_addr_high;
  logic [63:0] responder_addr_low;

  modport source (
    output valid, verdict, responder_addr_high, responder_addr_low,
    input  ready
  );
  modport sink (
    input  valid, verdict, responder_addr_high, responder_addr_low,
    output ready
  );
endinterface

// ===== rtl/prfd_hash.sv =====
// ----------------------------------------------------------------------------
// prfd_hash - three-lane MurmurHash3 x86_32 engine
// Checksum lane over address bytes 0..11, two filter lanes over all 16 bytes.
// Block keys are mixed in parallel, then one block round per cycle, then fmix.
// ----------------------------------------------------------------------------
module prfd_hash (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [63:0]        addr_hi,
  input  logic [63:0]        addr_lo,
  input  prfd_pkg::seeds_t   seeds,
  output prfd_pkg::hash_rsp_t rsp
);

  typedef enum logic [5:0] {
    HS_IDLE  = 6'b000001,
    HS_KMUL2 = 6'b000010,
    HS_ROUND = 6'b000100,
    HS_FMIX1 = 6'b001000,
    HS_FMIX2 = 6'b010000,
    HS_DONE  = 6'b100000
  } hash_state_t;

  hash_state_t state_r, state_nxt;
  logic [1:0]  blk_r;
  logic [31:0] k_r [4];
  logic [31:0] hc_r, h1_r, h2_r;
  logic [31:0] word [4];
  logic [31:0] k_sel;

  function automatic logic [31:0] bswap32(input logic [31:0] x);
    return {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

  function automatic logic [31:0] rotl15(input logic [31:0] x);
    return {x[16:0], x[31:17]};
  endfunction

  // h = rotl(h ^ k, 13) * 5 + n
  function automatic logic [31:0] round_h(input logic [31:0] h, input logic [31:0] k);
    logic [31:0] t;
    t = h ^ k;
    t = {t[18:0], t[31:19]};
    return t + {t[29:0], 2'b00} + prfd_pkg::MM_N;
  endfunction

  function automatic logic [31:0] pre_f1(input logic [31:0] h, input logic [31:0] len);
    logic [31:0] t;
    t = h ^ len;
    return t ^ (t >> 16);
  endfunction

  // byte 0 is the least significant byte of block 0
  assign word[0] = bswap32(addr_hi[63:32]);
  assign word[1] = bswap32(addr_hi[31:0]);
  assign word[2] = bswap32(addr_lo[63:32]);
  assign word[3] = bswap32(addr_lo[31:0]);
  assign k_sel   = k_r[blk_r];

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      HS_IDLE:  if (start) state_nxt = HS_KMUL2;
      HS_KMUL2: state_nxt = HS_ROUND;
      HS_ROUND: if (blk_r == 2'd3) state_nxt = HS_FMIX1;
      HS_FMIX1: state_nxt = HS_FMIX2;
      HS_FMIX2: state_nxt = HS_DONE;
      HS_DONE:  state_nxt = HS_IDLE;
      default:  state_nxt = HS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= HS_IDLE;
      blk_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == HS_ROUND) blk_r <= blk_r + 2'd1;
      else                     blk_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      HS_IDLE: begin
        if (start) begin
          for (int j = 0; j < 4; j++) k_r[j] <= word[j] * prfd_pkg::MM_C1;
          hc_r <= seeds.chk_seed;
          h1_r <= seeds.first_seed;
          h2_r <= seeds.second_seed;
        end
      end
      HS_KMUL2: begin
        for (int j = 0; j < 4; j++) k_r[j] <= rotl15(k_r[j]) * prfd_pkg::MM_C2;
      end
      HS_ROUND: begin
        // checksum lane covers the first three blocks only
        if (blk_r != 2'd3) hc_r <= round_h(hc_r, k_sel);
        h1_r <= round_h(h1_r, k_sel);
        h2_r <= round_h(h2_r, k_sel);
      end
      HS_FMIX1: begin
        hc_r <= pre_f1(hc_r, prfd_pkg::LEN_CHK) * prfd_pkg::MM_F1;
        h1_r <= pre_f1(h1_r, prfd_pkg::LEN_ALL) * prfd_pkg::MM_F1;
        h2_r <= pre_f1(h2_r, prfd_pkg::LEN_ALL) * prfd_pkg::MM_F1;
      end
      HS_FMIX2: begin
        hc_r <= (hc_r ^ (hc_r >> 13)) * prfd_pkg::MM_F2;
        h1_r <= (h1_r ^ (h1_r >> 13)) * prfd_pkg::MM_F2;
        h2_r <= (h2_r ^ (h2_r >> 13)) * prfd_pkg::MM_F2;
      end
      HS_DONE: ;
      default: ;
    endcase
  end

  assign rsp.done        = (state_r == HS_DONE);
  assign rsp.chk_hash    = hc_r ^ (hc_r >> 16);
  assign rsp.first_hash  = h1_r ^ (h1_r >> 16);
  assign rsp.second_hash = h2_r ^ (h2_r >> 16);

endmodule

// ===== rtl/prfd_bloom.sv =====
// ----------------------------------------------------------------------------
// prfd_bloom - Bloom filter bit store
// One-bit-wide synchronous memory, one read and one write port, registered
// read data. Swept to zero one entry per cycle after reset.
// ----------------------------------------------------------------------------
module prfd_bloom #(
  parameter int IDX_BITS = prfd_pkg::FILTER_INDEX_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  prfd_pkg::bloom_cmd_t  cmd,
  input  logic [IDX_BITS-1:0]   rd_addr,
  input  logic [IDX_BITS-1:0]   set_addr,
  output prfd_pkg::bloom_sts_t  sts
);

  localparam longint unsigned Depth = 64'd1 << IDX_BITS;

  logic                seen_r [Depth];
  logic                rd_bit_r;
  logic                clr_busy_r;
  logic [IDX_BITS-1:0] clr_cnt_r;
  logic                wr_en;
  logic [IDX_BITS-1:0] wr_addr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clr_busy_r) begin
      clr_cnt_r <= clr_cnt_r + IDX_BITS'(1);
      if (&clr_cnt_r) clr_busy_r <= 1'b0;
    end
  end

  assign wr_en   = clr_busy_r || cmd.set_en;
  assign wr_addr = clr_busy_r ? clr_cnt_r : set_addr;

  always_ff @(posedge clk) begin
    if (wr_en) seen_r[wr_addr] <= !clr_busy_r;
    if (cmd.rd_en) rd_bit_r <= seen_r[rd_addr];
  end

  assign sts.ready  = !clr_busy_r;
  assign sts.rd_bit = rd_bit_r;

  a_no_access_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !(cmd.rd_en || cmd.set_en))
    else $error("filter accessed during clearing sweep");

endmodule

// ===== rtl/probe_reply_filter_dedup_unit.sv =====
// ----------------------------------------------------------------------------
// probe_reply_filter_dedup_unit - probe reply filter with Bloom deduplication
// Classifies parsed IPv6 header fields, checks the embedded address checksum
// and drops repeated responders through a Bloom filter.
// ----------------------------------------------------------------------------
// One request is handled at a time. A frame rejected on ether type, next
// header or ICMPv6 type goes from acceptance straight to the output push.
// Other frames run through the three-lane hash engine (key mixing, four
// block rounds, two finalization multiplies): a bad checksum then goes to
// the push, while a good one reads both filter bits; a duplicate then goes
// to the push and an accepted frame first sets both bits in the filter.
// A new request is taken while the previous result still waits in the output
// register. After reset the filter memory is swept to zero, one entry per
// cycle; no request is taken until it ends, configuration writes are taken
// throughout. Seeds must be written only while idle; the block does not check it.
// ----------------------------------------------------------------------------
module probe_reply_filter_dedup_unit #(
  parameter int FILTER_INDEX_BITS = prfd_pkg::FILTER_INDEX_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  prfd_in_if.sink                        in_chan,
  prfd_out_if.source                     out_chan,
  input  logic                           cfg_wr_en,
  input  prfd_pkg::cfg_idx_t             cfg_index,
  input  logic [prfd_pkg::CFG_DATA_W-1:0] cfg_wr_data
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_HASH = 6'b000010,
    S_RD2  = 6'b000100,
    S_DEC  = 6'b001000,
    S_WR2  = 6'b010000,
    S_PUSH = 6'b100000
  } ctl_state_t;

  ctl_state_t               state_r, state_nxt;
  prfd_pkg::seeds_t         seeds_r;
  prfd_pkg::verdict_t       res_verdict_r;
  prfd_pkg::verdict_t       early_verdict;
  logic                     early_pass;
  logic [63:0]              addr_hi_r, addr_lo_r;
  logic [FILTER_INDEX_BITS-1:0] idx1_r, idx2_r;
  logic                     bit1_r;
  logic                     in_accept;
  logic                     hash_start;
  logic                     csum_ok;
  logic                     load_out;
  prfd_pkg::hash_rsp_t      hash_rsp;
  prfd_pkg::bloom_cmd_t     bloom_cmd;
  prfd_pkg::bloom_sts_t     bloom_sts;
  logic [FILTER_INDEX_BITS-1:0] rd_addr, set_addr;

  logic                     out_valid_r;
  prfd_pkg::verdict_t       out_verdict_r;
  logic [63:0]              out_hi_r, out_lo_r;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seeds_r.chk_seed    <= prfd_pkg::CHECKSUM_SEED_RST;
      seeds_r.first_seed  <= prfd_pkg::FIRST_SEED_RST;
      seeds_r.second_seed <= prfd_pkg::SECOND_SEED_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        prfd_pkg::CFG_CHECKSUM_SEED: seeds_r.chk_seed    <= cfg_wr_data;
        prfd_pkg::CFG_FIRST_SEED:    seeds_r.first_seed  <= cfg_wr_data;
        prfd_pkg::CFG_SECOND_SEED:   seeds_r.second_seed <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  // header classification, first failing test wins
  always_comb begin
    early_pass    = 1'b0;
    early_verdict = prfd_pkg::VERDICT_ACCEPT;
    priority if (in_chan.ether_type != prfd_pkg::ETHERTYPE_IPV6)
      early_verdict = prfd_pkg::VERDICT_NOT_IPV6;
    else if (in_chan.next_header != prfd_pkg::NEXT_HDR_ICMPV6)
      early_verdict = prfd_pkg::VERDICT_NOT_ICMPV6;
    else if (in_chan.icmp_type != prfd_pkg::ICMPV6_ECHO_REPLY &&
             in_chan.icmp_type != prfd_pkg::ICMPV6_NEIGH_ADVERT)
      early_verdict = prfd_pkg::VERDICT_WRONG_TYPE;
    else
      early_pass = 1'b1;
  end

  assign in_chan.ready = (state_r == S_IDLE) && bloom_sts.ready;
  assign in_accept     = in_chan.valid && in_chan.ready;
  assign hash_start    = in_accept && early_pass;
  assign csum_ok       = (hash_rsp.chk_hash == addr_lo_r[31:0]);
  assign load_out      = (state_r == S_PUSH) && (!out_valid_r || out_chan.ready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_accept) state_nxt = early_pass ? S_HASH : S_PUSH;
      S_HASH: if (hash_rsp.done) state_nxt = csum_ok ? S_RD2 : S_PUSH;
      S_RD2:  state_nxt = S_DEC;
      S_DEC:  state_nxt = (bit1_r && bloom_sts.rd_bit) ? S_PUSH : S_WR2;
      S_WR2:  state_nxt = S_PUSH;
      S_PUSH: if (load_out) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  // per-request working registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          res_verdict_r <= early_verdict;
          addr_hi_r     <= early_pass ? in_chan.src_addr_high : 64'd0;
          addr_lo_r     <= early_pass ? in_chan.src_addr_low  : 64'd0;
        end
      end
      S_HASH: begin
        if (hash_rsp.done) begin
          res_verdict_r <= csum_ok ? prfd_pkg::VERDICT_ACCEPT : prfd_pkg::VERDICT_CSUM_BAD;
          idx1_r        <= hash_rsp.first_hash[FILTER_INDEX_BITS-1:0];
          idx2_r        <= hash_rsp.second_hash[FILTER_INDEX_BITS-1:0];
        end
      end
      S_RD2: bit1_r <= bloom_sts.rd_bit;
      S_DEC: begin
        // one bit decides when both indexes coincide
        if (bit1_r && bloom_sts.rd_bit) res_verdict_r <= prfd_pkg::VERDICT_DUPLICATE;
      end
      S_WR2:  ;
      S_PUSH: ;
      default: ;
    endcase
  end

  // filter access: read idx1, read idx2, then, unless both bits were set, set idx1, set idx2
  always_comb begin
    bloom_cmd.rd_en  = ((state_r == S_HASH) && hash_rsp.done && csum_ok) ||
                       (state_r == S_RD2);
    bloom_cmd.set_en = ((state_r == S_DEC) && !(bit1_r && bloom_sts.rd_bit)) ||
                       (state_r == S_WR2);
    rd_addr  = (state_r == S_HASH) ? hash_rsp.first_hash[FILTER_INDEX_BITS-1:0] : idx2_r;
    set_addr = (state_r == S_DEC) ? idx1_r : idx2_r;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_verdict_r <= res_verdict_r;
      out_hi_r      <= addr_hi_r;
      out_lo_r      <= addr_lo_r;
    end
  end

  assign out_chan.valid               = out_valid_r;
  assign out_chan.verdict             = out_verdict_r;
  assign out_chan.responder_addr_high = out_hi_r;
  assign out_chan.responder_addr_low  = out_lo_r;

  prfd_hash u_hash (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (hash_start),
    .addr_hi (in_chan.src_addr_high),
    .addr_lo (in_chan.src_addr_low),
    .seeds   (seeds_r),
    .rsp     (hash_rsp)
  );

  prfd_bloom #(
    .IDX_BITS (FILTER_INDEX_BITS)
  ) u_bloom (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (bloom_cmd),
    .rd_addr  (rd_addr),
    .set_addr (set_addr),
    .sts      (bloom_sts)
  );

  a_early_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_verdict_r == prfd_pkg::VERDICT_NOT_IPV6 ||
                     out_verdict_r == prfd_pkg::VERDICT_NOT_ICMPV6 ||
                     out_verdict_r == prfd_pkg::VERDICT_WRONG_TYPE))
    |-> (out_hi_r == 64'd0 && out_lo_r == 64'd0))
    else $error("early reject carries an address");

  a_hash_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    hash_rsp.done |-> (state_r == S_HASH))
    else $error("hash result outside hash wait");

  a_set_means_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WR2) |=> (state_r == S_PUSH &&
                            res_verdict_r == prfd_pkg::VERDICT_ACCEPT))
    else $error("filter bits set for a request not accepted");

endmodule
